@@ rtl/core/srmat_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srmat_pkg
// Shared types and constants for the signed R-MAT edge generator.
// ----------------------------------------------------------------------------
package srmat_pkg;

   // Width of the Q0 probability fields (weights, draws and sign draws).
   localparam int PROB_BITS = 16;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

   localparam logic CSR_LEVELS = 1'b0;
   localparam logic CSR_ALPHA  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CHOOSE,
      ST_CMB_RD,
      ST_CMB_MUL,
      ST_CMB_MIX,
      ST_SIGN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load_wr;
      logic read_step;
      logic choose;
      logic cmb_start;
      logic cmb_read;
      logic cmb_mul;
      logic cmb_mix;
      logic sign;
      logic restart;
   } cmd_type;

   typedef struct packed {
      logic last_level;
      logic cmb_done;
   } status_type;

endpackage
`default_nettype wire

@@ rtl/core/srmat_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srmat_if
// Valid/ready channel carrying a payload of type PAYLOAD_TYPE.
// ----------------------------------------------------------------------------
interface srmat_if #(parameter type PAYLOAD_TYPE = logic) ();
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ rtl/core/srmat_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srmat_ctrl
// Controller: sequences loads, draw steps, level combination and output.
// ----------------------------------------------------------------------------
module srmat_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   input  wire                   req_op,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   input  wire                   csr_write,
   input  srmat_pkg::status_type status,
   output srmat_pkg::cmd_type    cmd
);
   srmat_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset || csr_write) begin
         state_ff <= srmat_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srmat_pkg::ST_IDLE: begin
            if (req_valid && req_op == srmat_pkg::OP_STEP) state_in = srmat_pkg::ST_READ;
         end
         srmat_pkg::ST_READ: state_in = srmat_pkg::ST_CHOOSE;
         srmat_pkg::ST_CHOOSE: begin
            state_in = status.last_level ? srmat_pkg::ST_CMB_RD : srmat_pkg::ST_IDLE;
         end
         srmat_pkg::ST_CMB_RD: begin
            state_in = status.cmb_done ? srmat_pkg::ST_SIGN : srmat_pkg::ST_CMB_MUL;
         end
         srmat_pkg::ST_CMB_MUL: state_in = srmat_pkg::ST_CMB_MIX;
         srmat_pkg::ST_CMB_MIX: state_in = srmat_pkg::ST_CMB_RD;
         srmat_pkg::ST_SIGN:    state_in = srmat_pkg::ST_OUT;
         srmat_pkg::ST_OUT: begin
            if (rsp_ready) state_in = srmat_pkg::ST_IDLE;
         end
         default: state_in = srmat_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         srmat_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_wr   = (req_op == srmat_pkg::OP_LOAD);
               cmd.read_step = (req_op == srmat_pkg::OP_STEP);
            end
         end
         srmat_pkg::ST_CHOOSE: begin
            cmd.choose    = 1'b1;
            cmd.cmb_start = status.last_level;
         end
         srmat_pkg::ST_CMB_RD:  cmd.cmb_read = 1'b1;
         srmat_pkg::ST_CMB_MUL: cmd.cmb_mul  = 1'b1;
         srmat_pkg::ST_CMB_MIX: cmd.cmb_mix  = 1'b1;
         srmat_pkg::ST_SIGN:    cmd.sign     = 1'b1;
         srmat_pkg::ST_OUT: begin
            rsp_valid   = 1'b1;
            cmd.restart = rsp_ready;
         end
         default: cmd = '0;
      endcase
   end
endmodule
`default_nettype wire

@@ rtl/core/srmat_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srmat_dp
// Datapath: weight memory, quadrant choice, mass combination and sign test.
// ----------------------------------------------------------------------------
module srmat_dp #(
   parameter int MAX_LEVELS = 32
) (
   input  wire                   clock,
   input  wire                   reset,
   input  srmat_pkg::cmd_type    cmd,
   output srmat_pkg::status_type status,
   input  wire                   csr_write,
   input  wire                   csr_index,
   input  wire [15:0]            csr_data,
   input  wire [5:0]             load_level,
   input  wire [15:0]            weight_top_left,
   input  wire [15:0]            weight_top_right,
   input  wire [15:0]            weight_bottom_left,
   input  wire [15:0]            weight_bottom_right,
   input  wire [15:0]            draw,
   input  wire [15:0]            sign_draw,
   output logic [32:0]           source_node,
   output logic [32:0]           target_node,
   output logic                  positive
);
   localparam int PROB_BITS = srmat_pkg::PROB_BITS;
   localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int MW = 6;
   localparam logic [PROB_BITS-1:0] PMASK = '1;

   logic [4*PROB_BITS-1:0] wmem [MAX_LEVELS];
   logic [1:0]             quad_ff [MAX_LEVELS];
   logic [4*PROB_BITS-1:0] rd_ff;
   logic [MW-1:0] levels_ff, cur_ff, cmb_ff;
   logic [15:0]   alpha_ff;
   logic [MAX_LEVELS-1:0] row_ff, col_ff;
   logic [PROB_BITS-1:0]  draw_ff, sd_ff;
   logic [31:0] p_ff, n_ff;
   logic [63:0] tp_ff, tn_ff;
   logic [1:0]  q_ff;
   logic        first_ff;
   logic [PROB_BITS-1:0] w_sel;
   logic [PROB_BITS+1:0] c0, c1, c2;
   logic [1:0]  q_new;
   logic [MW-1:0] lv_sat;
   logic [LW-1:0] cur_idx, cmb_idx, wr_idx;
   logic [63:0] sh_p, sh_n;
   logic [47:0] mix_a, mix_b;
   logic [32:0] total;
   logic [32+PROB_BITS:0] lhs, rhs;
   logic        pos_ff;

   assign cur_idx = LW'(cur_ff - MW'(1));
   assign cmb_idx = LW'(cmb_ff - MW'(1));
   assign wr_idx  = LW'(load_level - 6'd1);

   always_comb begin
      lv_sat = csr_data[5:0];
      if (lv_sat == '0) lv_sat = MW'(1);
      if (lv_sat > MW'(MAX_LEVELS)) lv_sat = MW'(MAX_LEVELS);
   end

   // Weight memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.load_wr && load_level != 6'd0 && load_level <= 6'(MAX_LEVELS)) begin
         wmem[wr_idx] <= {weight_bottom_right[PROB_BITS-1:0] & PMASK,
                          weight_bottom_left[PROB_BITS-1:0],
                          weight_top_right[PROB_BITS-1:0],
                          weight_top_left[PROB_BITS-1:0]};
      end
      if (cmd.read_step) rd_ff <= wmem[cur_idx];
      else if (cmd.cmb_read) rd_ff <= wmem[cmb_idx];
   end

   always_comb begin
      c0 = {2'b0, rd_ff[PROB_BITS-1:0]};
      c1 = c0 + {2'b0, rd_ff[2*PROB_BITS-1:PROB_BITS]};
      c2 = c1 + {2'b0, rd_ff[3*PROB_BITS-1:2*PROB_BITS]};
      if ({2'b0, draw_ff} < c0) q_new = 2'd0;
      else if ({2'b0, draw_ff} < c1) q_new = 2'd1;
      else if ({2'b0, draw_ff} < c2) q_new = 2'd2;
      else q_new = 2'd3;
   end

   always_comb begin
      case (q_ff)
         2'd0: w_sel = rd_ff[PROB_BITS-1:0];
         2'd1: w_sel = rd_ff[2*PROB_BITS-1:PROB_BITS];
         2'd2: w_sel = rd_ff[3*PROB_BITS-1:2*PROB_BITS];
         default: w_sel = rd_ff[4*PROB_BITS-1:3*PROB_BITS];
      endcase
   end

   // Normalizing shift: smallest amount bringing both products below 2^31.
   always_comb begin
      logic [63:0] orv;
      logic [6:0]  sh;
      orv = tp_ff | tn_ff;
      sh  = '0;
      for (int b = 31; b < 64; b++) begin
         if (orv[b]) sh = 7'(b - 30);
      end
      sh_p = tp_ff >> sh;
      sh_n = tn_ff >> sh;
   end

   assign mix_a = {16'b0, sh_n[31:0]} * {32'b0, alpha_ff};
   assign mix_b = {16'b0, sh_n[31:0]} * {31'b0, 17'h10000 - {1'b0, alpha_ff}};

   assign status.last_level = (cur_ff == MW'(1));
   assign status.cmb_done   = (cmb_ff > levels_ff);

   assign total = {1'b0, p_ff} + {1'b0, n_ff};
   assign lhs   = (33+PROB_BITS)'(total) * (33+PROB_BITS)'(sd_ff);
   assign rhs   = {1'b0, p_ff, {PROB_BITS{1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= MW'(1);
         alpha_ff  <= '0;
         cur_ff    <= MW'(1);
         row_ff    <= '0;
         col_ff    <= '0;
         p_ff      <= '0;
         n_ff      <= '0;
         for (int i = 0; i < MAX_LEVELS; i++) quad_ff[i] <= 2'd0;
      end else if (csr_write) begin
         if (csr_index == srmat_pkg::CSR_LEVELS) begin
            levels_ff <= lv_sat;
            cur_ff    <= lv_sat;
            row_ff    <= '0;
            col_ff    <= '0;
         end else begin
            alpha_ff <= csr_data;
         end
      end else begin
         if (cmd.read_step) begin
            draw_ff <= draw[PROB_BITS-1:0];
            sd_ff   <= sign_draw[PROB_BITS-1:0];
         end
         if (cmd.choose) begin
            quad_ff[cur_idx] <= q_new;
            if (q_new[1]) row_ff[cur_idx] <= 1'b1;
            if (q_new[0]) col_ff[cur_idx] <= 1'b1;
            if (!status.last_level) cur_ff <= cur_ff - MW'(1);
         end
         if (cmd.cmb_start) begin
            cmb_ff   <= MW'(1);
            first_ff <= 1'b1;
         end
         if (cmd.cmb_read) q_ff <= quad_ff[cmb_idx];
         if (cmd.cmb_mul) begin
            if (first_ff) begin
               tp_ff <= (q_ff == 2'd0 || q_ff == 2'd3) ? 64'(w_sel) : 64'd0;
               tn_ff <= (q_ff == 2'd0 || q_ff == 2'd3) ? 64'd0 : 64'(w_sel);
            end else if (q_ff == 2'd0 || q_ff == 2'd3) begin
               tp_ff <= 64'(p_ff) * 64'(w_sel);
               tn_ff <= 64'(n_ff) * 64'(w_sel);
            end else begin
               tp_ff <= 64'(n_ff) * 64'(w_sel);
               tn_ff <= 64'(p_ff) * 64'(w_sel);
            end
         end
         if (cmd.cmb_mix) begin
            if (first_ff) begin
               p_ff <= tp_ff[31:0];
               n_ff <= tn_ff[31:0];
            end else begin
               p_ff <= sh_p[31:0] + mix_a[47:16];
               n_ff <= mix_b[47:16];
            end
            first_ff <= 1'b0;
            cmb_ff   <= cmb_ff + MW'(1);
         end
         if (cmd.sign) pos_ff <= (lhs < rhs);
         if (cmd.restart) begin
            cur_ff <= levels_ff;
            row_ff <= '0;
            col_ff <= '0;
         end
      end
   end

   assign source_node = 33'(row_ff) + 33'd1;
   assign target_node = 33'(col_ff) + 33'd1;
   assign positive    = pos_ff;
endmodule
`default_nettype wire

@@ rtl/core/signed_rmat_edge_generator_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// signed_rmat_edge_generator_top
// Signed R-MAT edge generator: per-level quadrant draws, signed mass combine.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// req       in   op, load_level, four weights, draw, sign_draw
// rsp       out  source_node, target_node, positive
// csr       in   csr_write, csr_index, csr_data (levels, alpha)
//
// A load is taken in the idle state; a draw step passes through the read
// and choose states. The level-1 step then walks all levels, one at a time,
// through the read, multiply and mix states, then the sign and output states.
// Reset is synchronous; a csr write abandons the walk. The result register
// holds until rsp_ready is seen.
module signed_rmat_edge_generator_top #(
   parameter int MAX_LEVELS = 32
) (
   input  wire        clock,
   input  wire        reset,
   srmat_if.sink      req,
   srmat_if.source    rsp,
   input  wire        csr_write,
   input  wire        csr_index,
   input  wire [15:0] csr_data
);
   srmat_pkg::cmd_type    cmd;
   srmat_pkg::status_type status;

   srmat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_op    (req.payload.op),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .csr_write (csr_write),
      .status    (status),
      .cmd       (cmd)
   );

   srmat_dp #(.MAX_LEVELS(MAX_LEVELS)) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .load_level          (req.payload.load_level),
      .weight_top_left     (req.payload.weight_top_left),
      .weight_top_right    (req.payload.weight_top_right),
      .weight_bottom_left  (req.payload.weight_bottom_left),
      .weight_bottom_right (req.payload.weight_bottom_right),
      .draw                (req.payload.draw),
      .sign_draw           (req.payload.sign_draw),
      .source_node         (rsp.payload.source_node),
      .target_node         (rsp.payload.target_node),
      .positive            (rsp.payload.positive)
   );
endmodule
`default_nettype wire

@@ rtl/core/srmat_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srmat_checker
// Port-level checks for the signed R-MAT edge generator.
// ----------------------------------------------------------------------------
module srmat_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_ready,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire        csr_write,
   input wire [32:0] src,
   input wire [32:0] dst
);
   // A pending result is never dropped without a transaction or a csr write.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && !csr_write |=> rsp_valid)
      else $error("result dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && !csr_write |=> $stable(src) && $stable(dst))
      else $error("result changed while stalled");

   // The block works on one item at a time.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while result pending");

   a_nodes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> src != 33'd0 && dst != 33'd0)
      else $error("zero node index");
endmodule

bind signed_rmat_edge_generator_top srmat_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .csr_write (csr_write),
   .src       (rsp.payload.source_node),
   .dst       (rsp.payload.target_node)
);
`default_nettype wire

@@ test/srmat_tb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmat_tb_pkg
// Transaction payload types for the request and edge channels of the signed
// R-MAT edge generator testbench.
// ----------------------------------------------------------------------------
package srmat_tb_pkg;

   typedef struct packed {
      logic        op;
      logic [5:0]  load_level;
      logic [15:0] weight_top_left;
      logic [15:0] weight_top_right;
      logic [15:0] weight_bottom_left;
      logic [15:0] weight_bottom_right;
      logic [15:0] draw;
      logic [15:0] sign_draw;
   } edge_req_type;

   typedef struct packed {
      logic [32:0] source_node;
      logic [32:0] target_node;
      logic        positive;
   } edge_rsp_type;

endpackage

@@ test/srmat_edge_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmat_edge_checker
// Watches the request, edge and register ports, predicts each edge from the
// accepted transactions and compares it field by field with the block.
// ----------------------------------------------------------------------------
module srmat_edge_checker (
   input  wire         clock,
   input  wire         reset,
   srmat_if            req,
   srmat_if            rsp,
   input  wire         csr_write,
   input  wire         csr_index,
   input  wire  [15:0] csr_data,
   output int          failures,
   output int          pending
);

   logic [15:0] weights [32][4];
   logic [1:0]  quadrants [32];
   logic [5:0]  depth;
   logic [15:0] alpha;
   logic [5:0]  walk_level;
   logic [31:0] rows;
   logic [31:0] cols;
   srmat_tb_pkg::edge_rsp_type expected_edges [$];

   assign pending = expected_edges.size();

   function automatic logic diagonal(input logic [1:0] q);
      return q == 2'd0 || q == 2'd3;
   endfunction

   task automatic predict_edge(input srmat_tb_pkg::edge_req_type t);
      logic [17:0] c0, c1, c2;
      logic [1:0]  q;
      logic [63:0] p, n, tp, tn, w;
      logic [63:0] total;
      srmat_tb_pkg::edge_rsp_type e;
      if (t.op == srmat_pkg::OP_LOAD) begin
         if (t.load_level >= 1 && t.load_level <= 32) begin
            weights[t.load_level - 1][0] = t.weight_top_left;
            weights[t.load_level - 1][1] = t.weight_top_right;
            weights[t.load_level - 1][2] = t.weight_bottom_left;
            weights[t.load_level - 1][3] = t.weight_bottom_right;
         end
         return;
      end
      c0 = 18'(weights[walk_level - 1][0]);
      c1 = c0 + 18'(weights[walk_level - 1][1]);
      c2 = c1 + 18'(weights[walk_level - 1][2]);
      if ({2'b0, t.draw} < c0) q = 2'd0;
      else if ({2'b0, t.draw} < c1) q = 2'd1;
      else if ({2'b0, t.draw} < c2) q = 2'd2;
      else q = 2'd3;
      quadrants[walk_level - 1] = q;
      if (q[1]) rows[walk_level - 1] = 1'b1;
      if (q[0]) cols[walk_level - 1] = 1'b1;
      if (walk_level > 1) begin
         walk_level = walk_level - 1;
         return;
      end
      w = weights[0][quadrants[0]];
      p = diagonal(quadrants[0]) ? w : 64'd0;
      n = diagonal(quadrants[0]) ? 64'd0 : w;
      for (int l = 2; l <= depth; l++) begin
         w = weights[l - 1][quadrants[l - 1]];
         tp = diagonal(quadrants[l - 1]) ? p * w : n * w;
         tn = diagonal(quadrants[l - 1]) ? n * w : p * w;
         while (((tp | tn) >> 31) != 0) begin
            tp = tp >> 1;
            tn = tn >> 1;
         end
         p = tp + ((64'(alpha) * tn) >> 16);
         n = ((64'd65536 - 64'(alpha)) * tn) >> 16;
      end
      p = p & 64'hFFFF_FFFF;
      n = n & 64'hFFFF_FFFF;
      total = p + n;
      e.source_node = {1'b0, rows} + 33'd1;
      e.target_node = {1'b0, cols} + 33'd1;
      e.positive = (64'(t.sign_draw) * total) < (p << 16);
      expected_edges.insert(expected_edges.size(), e);
      walk_level = depth;
      rows = '0;
      cols = '0;
   endtask

   always @(posedge clock) begin
      srmat_tb_pkg::edge_rsp_type want;
      srmat_tb_pkg::edge_rsp_type got;
      if (reset) begin
         foreach (quadrants[i]) quadrants[i] = '0;
         depth = 6'd1;
         alpha = '0;
         walk_level = 6'd1;
         rows = '0;
         cols = '0;
         failures = 0;
      end else begin
         if (csr_write) begin
            if (csr_index == srmat_pkg::CSR_LEVELS) begin
               depth = csr_data[5:0];
               if (depth < 1) depth = 6'd1;
               if (depth > 32) depth = 6'd32;
               walk_level = depth;
               rows = '0;
               cols = '0;
            end else begin
               alpha = csr_data;
            end
         end
         if (req.valid && req.ready) predict_edge(req.payload);
         if (rsp.valid && rsp.ready) begin
            got = rsp.payload;
            if (expected_edges.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("ERROR: edge with none expected: src=%0d dst=%0d pos=%0b",
                     got.source_node, got.target_node, got.positive);
            end else begin
               want = expected_edges.pop_front();
               if (got !== want) begin
                  failures++;
                  if (failures <= 10)
                     $display({"ERROR: edge mismatch: exp src=%0d dst=%0d pos=%0b,",
                               " got src=%0d dst=%0d pos=%0b"},
                        want.source_node, want.target_node, want.positive,
                        got.source_node, got.target_node, got.positive);
               end
            end
         end
      end
   end

endmodule

@@ test/signed_rmat_edge_generator_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_rmat_edge_generator_top_tb
// Drives directed and random load and draw transactions through the edge
// generator across several depth and mixing settings, with random stalls.
// ----------------------------------------------------------------------------
module signed_rmat_edge_generator_top_tb;

   localparam int CYCLE_LIMIT = 1500000;
   localparam int DRAIN_CYCLES = 150;
   localparam int TARGET_ITEMS = 1650;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic        csr_index = srmat_pkg::CSR_LEVELS;
   logic [15:0] csr_data = '0;
   int          failures;
   int          pending;
   int          cycles = 0;
   int          items_sent = 0;
   logic        quiet = 1'b0;
   logic        hold_request = 1'b0;

   srmat_if #(.PAYLOAD_TYPE(srmat_tb_pkg::edge_req_type)) req_ch ();
   srmat_if #(.PAYLOAD_TYPE(srmat_tb_pkg::edge_rsp_type)) rsp_ch ();

   signed_rmat_edge_generator_top i_dut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   srmat_edge_checker i_checker (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .failures(failures), .pending(pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Edge receiver: random back-pressure, plus long hold-offs on request.
   initial begin
      rsp_ch.ready = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (hold_request) begin
            rsp_ch.ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_request <= 1'b0;
            @(posedge clock);
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   task automatic send(input srmat_tb_pkg::edge_req_type t);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= t;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   task automatic write_reg(input logic idx, input logic [15:0] value);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic srmat_tb_pkg::edge_req_type load_item(input logic [5:0] lvl,
                                                            input logic [15:0] a,
                                                            input logic [15:0] b,
                                                            input logic [15:0] c,
                                                            input logic [15:0] d);
      srmat_tb_pkg::edge_req_type t;
      t = '0;
      t.op = srmat_pkg::OP_LOAD;
      t.load_level = lvl;
      t.weight_top_left = a;
      t.weight_top_right = b;
      t.weight_bottom_left = c;
      t.weight_bottom_right = d;
      t.draw = 16'($urandom);
      t.sign_draw = 16'($urandom);
      return t;
   endfunction

   function automatic srmat_tb_pkg::edge_req_type step_item(input logic [15:0] dr,
                                                            input logic [15:0] sd);
      srmat_tb_pkg::edge_req_type t;
      t = '0;
      t.op = srmat_pkg::OP_STEP;
      t.load_level = 6'($urandom);
      t.weight_top_left = 16'($urandom);
      t.weight_top_right = 16'($urandom);
      t.weight_bottom_left = 16'($urandom);
      t.weight_bottom_right = 16'($urandom);
      t.draw = dr;
      t.sign_draw = sd;
      return t;
   endfunction

   function automatic logic [15:0] pick16();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Random weights; mostly a proper distribution, sometimes anything.
   function automatic srmat_tb_pkg::edge_req_type random_load(input logic [5:0] lvl);
      if ($urandom_range(0, 3) == 0)
         return load_item(lvl, pick16(), pick16(), pick16(), pick16());
      return load_item(lvl, 16'($urandom_range(0, 16383)), 16'($urandom_range(0, 16383)),
                       16'($urandom_range(0, 16383)), 16'($urandom_range(0, 16383)));
   endfunction

   initial begin
      int         phase_len;
      logic [5:0] lvl;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_reg(srmat_pkg::CSR_LEVELS, 16'd1);
      write_reg(srmat_pkg::CSR_ALPHA, 16'd0);
      for (int l = 1; l <= 32; l++) send(random_load(6'(l)));

      // Single-level corners: zero mass, each quadrant, draw extremes.
      send(load_item(6'd1, 16'd0, 16'd0, 16'd0, 16'd0));
      send(step_item(16'h0000, 16'hFFFF));
      send(load_item(6'd1, 16'hFFFF, 16'd0, 16'd0, 16'd0));
      send(step_item(16'h0000, 16'hFFFF));
      send(step_item(16'h0000, 16'h0000));
      send(load_item(6'd1, 16'd0, 16'hFFFF, 16'd0, 16'd0));
      send(step_item(16'h0000, 16'h0000));
      send(load_item(6'd1, 16'd0, 16'd0, 16'hFFFF, 16'd0));
      send(step_item(16'hFFFE, 16'h8000));
      send(step_item(16'hFFFF, 16'h8000));
      send(load_item(6'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send(step_item(16'hFFFF, 16'h0001));
      // Out-of-range loads are dropped.
      send(load_item(6'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send(load_item(6'd33, 16'd0, 16'd0, 16'd0, 16'd0));
      send(load_item(6'd63, 16'd0, 16'd0, 16'd0, 16'd0));
      send(step_item(16'h1234, 16'h4321));

      // Depth saturation at both ends, then a full-depth walk at both alpha extremes.
      write_reg(srmat_pkg::CSR_LEVELS, 16'h0000);
      send(step_item(16'hFFFF, 16'hFFFF));
      write_reg(srmat_pkg::CSR_LEVELS, 16'hFFFF);
      write_reg(srmat_pkg::CSR_ALPHA, 16'hFFFF);
      repeat (32) send(step_item(pick16(), pick16()));
      write_reg(srmat_pkg::CSR_ALPHA, 16'h0000);
      repeat (32) send(step_item(pick16(), pick16()));

      while (items_sent < TARGET_ITEMS) begin
         if (items_sent > TARGET_ITEMS - 250) quiet = 1'b1;
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: lvl = 6'($urandom_range(1, 6));
            6, 7: lvl = 6'($urandom_range(7, 16));
            8: lvl = 6'd32;
            default: lvl = 6'($urandom_range(0, 63));
         endcase
         write_reg(srmat_pkg::CSR_LEVELS, {10'($urandom), lvl});
         write_reg(srmat_pkg::CSR_ALPHA, pick16());
         phase_len = $urandom_range(40, 90);
         for (int i = 0; i < phase_len; i++) begin
            if (items_sent > 400 && items_sent < 500 && i == 5) hold_request <= 1'b1;
            if (items_sent > 800 && items_sent < 900 && i == 10) begin
               req_ch.valid <= 1'b0;
               @(posedge clock);
               while (pending != 0) @(posedge clock);
            end
            if ($urandom_range(0, 6) == 0) send(random_load(6'($urandom_range(0, 63))));
            else send(step_item(pick16(), pick16()));
         end
      end

      req_ch.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/srmat_pkg.sv
rtl/core/srmat_if.sv
rtl/core/srmat_ctrl.sv
rtl/core/srmat_dp.sv
rtl/core/signed_rmat_edge_generator_top.sv
rtl/core/srmat_checker.sv
test/srmat_tb_pkg.sv
test/srmat_edge_checker.sv
test/signed_rmat_edge_generator_top_tb.sv
